// File: rtl/ship_pkg.sv
// Shared beat types, action codes, controller states and control structs.
`timescale 1ns / 1ps

package ship_pkg;

    localparam logic [1:0] ACT_HIT    = 2'd0;
    localparam logic [1:0] ACT_FILL   = 2'd1;
    localparam logic [1:0] ACT_VICTIM = 2'd2;

    typedef struct packed {
        logic [1:0]  action;
        logic [9:0]  set_index;
        logic [3:0]  way;
        logic [13:0] signature;
    } t_in_beat;

    typedef struct packed {
        logic [3:0] victim_way;
        logic       victim_invalid;
    } t_out_beat;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REDUCE,
        ST_EVAL,
        ST_COUNT,
        ST_PUSH
    } t_state;

    typedef struct packed {
        logic clr;
        logic load;
        logic reduce;
        logic eval;
        logic count;
        logic push;
    } t_dp_cmd;

    typedef struct packed {
        logic       clr_last;
        logic [1:0] act;
        logic       way_ok;
        logic       train;
        logic       out_free;
    } t_dp_sts;

endpackage

// File: rtl/ship_ctrl.sv
// Sequencer for clearing, reduction, evaluation, counter training and result push.
`timescale 1ns / 1ps

module ship_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  ship_pkg::t_dp_sts i_sts,
    output ship_pkg::t_dp_cmd o_cmd
);
    import ship_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (i_sts.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_REDUCE;
            end
            ST_REDUCE: begin
                n_state = ST_EVAL;
            end
            ST_EVAL: begin
                case (i_sts.act)
                    ACT_HIT:    n_state = i_sts.way_ok ? ST_COUNT : ST_IDLE;
                    ACT_VICTIM: n_state = i_sts.train ? ST_COUNT : ST_PUSH;
                    default:    n_state = ST_IDLE;
                endcase
            end
            ST_COUNT: begin
                n_state = (i_sts.act == ACT_VICTIM) ? ST_PUSH : ST_IDLE;
            end
            ST_PUSH: begin
                if (i_sts.out_free) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_CLEAR:  o_cmd.clr = 1'b1;
            ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            ST_REDUCE: o_cmd.reduce = 1'b1;
            ST_EVAL:   o_cmd.eval = 1'b1;
            ST_COUNT:  o_cmd.count = 1'b1;
            ST_PUSH:   o_cmd.push = i_sts.out_free;
            default:   o_cmd = '0;
        endcase
    end

    a_count_after_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COUNT) |-> ($past(r_state) == ST_EVAL))
        else $error("counter update not preceded by evaluation");

    a_push_victim_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PUSH) |-> (i_sts.act == ACT_VICTIM))
        else $error("result push for a non-victim beat");

    a_reduce_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_REDUCE) |-> $past(o_cmd.load))
        else $error("reduction without a loaded beat");

endmodule

// File: rtl/ship_dp.sv
// Line-state and counter memories, index reduction, victim search and result register.
`timescale 1ns / 1ps

module ship_dp #(
    parameter int RRPV_BITS     = 2,
    parameter int COUNTER_BITS  = 3,
    parameter int TABLE_ENTRIES = 16384,
    parameter int NUM_WAYS      = 16,
    parameter int NUM_SETS      = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ship_pkg::t_in_beat   i_in_beat,
    input  logic                 i_cfg_wr_en,
    input  logic                 i_cfg_wr_data,
    input  logic                 i_out_stall,
    output logic                 o_out_valid,
    output ship_pkg::t_out_beat  o_out_beat,
    input  ship_pkg::t_dp_cmd    i_cmd,
    output ship_pkg::t_dp_sts    o_sts
);
    import ship_pkg::*;

    localparam int SET_W   = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int SLOT_W  = $clog2(TABLE_ENTRIES);
    localparam int WAY_W   = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int CLR_N   = (NUM_SETS > TABLE_ENTRIES) ? NUM_SETS : TABLE_ENTRIES;
    localparam int CLR_W   = $clog2(CLR_N);
    localparam int LVLS    = 1 << RRPV_BITS;
    localparam logic [RRPV_BITS-1:0]    RRPV_MAX = RRPV_BITS'(LVLS - 1);
    localparam logic [COUNTER_BITS-1:0] CTR_MAX  = COUNTER_BITS'((1 << COUNTER_BITS) - 1);
    // Reciprocals scaled by 2^30; the estimated quotient is low by at most one.
    localparam logic [30:0] SIG_RECIP = 31'((64'd1 << 30) / TABLE_ENTRIES);
    localparam logic [30:0] SET_RECIP = 31'((64'd1 << 30) / NUM_SETS);

    typedef struct packed {
        logic [NUM_WAYS-1:0]                valid;
        logic [NUM_WAYS-1:0]                reused;
        logic [NUM_WAYS-1:0][RRPV_BITS-1:0] rrpv;
        logic [NUM_WAYS-1:0][SLOT_W-1:0]    slot;
    } t_row;

    t_row                    row_mem [NUM_SETS];
    logic [COUNTER_BITS-1:0] ctr_mem [TABLE_ENTRIES];

    t_in_beat                r_item;
    logic [14:0]             r_sig_q;
    logic [10:0]             r_set_q;
    logic [SET_W-1:0]        r_set;
    logic [SLOT_W-1:0]       r_slot_new;
    t_row                    r_row;
    logic [COUNTER_BITS-1:0] r_ctr;
    logic [SLOT_W-1:0]       r_ctr_addr;
    logic [CLR_W-1:0]        r_clr_idx;
    logic                    r_hit_prio;
    t_out_beat               r_res;
    logic                    r_out_valid;
    t_out_beat               r_out;

    logic [44:0]             sig_prod;
    logic [40:0]             set_prod;
    logic [31:0]             sig_rem;
    logic [31:0]             set_rem;
    logic [SLOT_W-1:0]       slot_r;
    logic [SET_W-1:0]        set_r;

    logic [WAY_W-1:0]        way_sel;
    logic                    way_ok;
    logic [LVLS-1:0]         any_lvl;
    logic [RRPV_BITS-1:0]    best;
    logic [RRPV_BITS-1:0]    diff;
    logic [RRPV_BITS:0]      aged;
    logic [WAY_W-1:0]        vic;
    logic [WAY_W-1:0]        inv;
    logic                    all_valid;
    logic                    train;
    t_row                    row_new;
    logic                    row_we;
    logic [SET_W-1:0]        row_waddr;
    t_row                    row_wdata;
    logic [SLOT_W-1:0]       ctr_raddr;
    logic                    ctr_we;
    logic [SLOT_W-1:0]       ctr_waddr;
    logic [COUNTER_BITS-1:0] ctr_wdata;

    assign sig_prod = {31'b0, i_in_beat.signature} * {14'b0, SIG_RECIP};
    assign set_prod = {31'b0, i_in_beat.set_index} * {10'b0, SET_RECIP};

    // Finish both remainders: subtract the quotient product, correct once.
    always_comb begin
        sig_rem = 32'(r_item.signature) - 32'(r_sig_q) * 32'(TABLE_ENTRIES);
        if (sig_rem >= 32'(TABLE_ENTRIES)) sig_rem = sig_rem - 32'(TABLE_ENTRIES);
        set_rem = 32'(r_item.set_index) - 32'(r_set_q) * 32'(NUM_SETS);
        if (set_rem >= 32'(NUM_SETS)) set_rem = set_rem - 32'(NUM_SETS);
        slot_r = SLOT_W'(sig_rem);
        set_r  = SET_W'(set_rem);
    end

    assign way_sel   = WAY_W'(r_item.way);
    assign way_ok    = ({28'b0, r_item.way} < 32'(NUM_WAYS));
    assign all_valid = &r_row.valid;

    always_comb begin
        for (int v = 0; v < LVLS; v++) begin
            any_lvl[v] = 1'b0;
            for (int w = 0; w < NUM_WAYS; w++) begin
                if (r_row.rrpv[w] == RRPV_BITS'(v)) any_lvl[v] = 1'b1;
            end
        end
        best = '0;
        for (int v = 0; v < LVLS; v++) begin
            if (any_lvl[v]) best = RRPV_BITS'(v);
        end
        vic = '0;
        inv = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (r_row.rrpv[w] == best) vic = WAY_W'(w);
            if (!r_row.valid[w]) inv = WAY_W'(w);
        end
        diff  = RRPV_MAX - best;
        train = (r_item.action == ACT_VICTIM) && all_valid && !r_row.reused[vic];
    end

    always_comb begin
        row_new = r_row;
        aged    = '0;
        case (r_item.action)
            ACT_HIT: begin
                row_new.reused[way_sel] = 1'b1;
                if (r_hit_prio) begin
                    row_new.rrpv[way_sel] = '0;
                end else if (r_row.rrpv[way_sel] != '0) begin
                    row_new.rrpv[way_sel] = r_row.rrpv[way_sel] - 1'b1;
                end
            end
            ACT_FILL: begin
                row_new.rrpv[way_sel]   = (r_ctr != '0) ? RRPV_MAX - 1'b1 : RRPV_MAX;
                row_new.slot[way_sel]   = r_slot_new;
                row_new.valid[way_sel]  = 1'b1;
                row_new.reused[way_sel] = 1'b0;
            end
            ACT_VICTIM: begin
                for (int w = 0; w < NUM_WAYS; w++) begin
                    aged = {1'b0, r_row.rrpv[w]} + {1'b0, diff};
                    row_new.rrpv[w] = (aged > {1'b0, RRPV_MAX}) ? RRPV_MAX
                                                                : aged[RRPV_BITS-1:0];
                end
            end
            default: row_new = r_row;
        endcase
    end

    always_comb begin
        row_we    = 1'b0;
        row_waddr = r_set;
        row_wdata = row_new;
        if (i_cmd.clr) begin
            row_we       = (32'(r_clr_idx) < 32'(NUM_SETS));
            row_waddr    = SET_W'(r_clr_idx);
            row_wdata    = '0;
        end else if (i_cmd.eval) begin
            if (r_item.action inside {ACT_HIT, ACT_FILL}) begin
                row_we = way_ok;
            end else if (r_item.action == ACT_VICTIM) begin
                row_we = all_valid;
            end
        end
    end

    always_comb begin
        ctr_raddr = (r_item.action == ACT_HIT) ? r_row.slot[way_sel] : r_row.slot[vic];
        if (i_cmd.reduce) ctr_raddr = slot_r;
        ctr_we    = i_cmd.clr || i_cmd.count;
        ctr_waddr = i_cmd.clr ? SLOT_W'(r_clr_idx) : r_ctr_addr;
        if (i_cmd.clr) begin
            ctr_wdata = '0;
        end else if (r_item.action == ACT_HIT) begin
            ctr_wdata = (r_ctr == CTR_MAX) ? r_ctr : r_ctr + 1'b1;
        end else begin
            ctr_wdata = (r_ctr == '0) ? r_ctr : r_ctr - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (row_we) row_mem[row_waddr] <= row_wdata;
        if (i_cmd.reduce) r_row <= row_mem[set_r];
        if (ctr_we && (32'(r_clr_idx) < 32'(TABLE_ENTRIES) || !i_cmd.clr)) begin
            ctr_mem[ctr_waddr] <= ctr_wdata;
        end
        if (i_cmd.reduce || i_cmd.eval) r_ctr <= ctr_mem[ctr_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item  <= i_in_beat;
            r_sig_q <= sig_prod[44:30];
            r_set_q <= set_prod[40:30];
        end
        if (i_cmd.reduce) begin
            r_set      <= set_r;
            r_slot_new <= slot_r;
        end
        if (i_cmd.eval) begin
            r_ctr_addr           <= ctr_raddr;
            r_res.victim_way     <= all_valid ? 4'(vic) : 4'(inv);
            r_res.victim_invalid <= !all_valid;
        end
        if (i_cmd.push) r_out <= r_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx   <= '0;
            r_hit_prio  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr) r_clr_idx <= r_clr_idx + 1'b1;
            if (i_cfg_wr_en) r_hit_prio <= i_cfg_wr_data;
            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_beat     = r_out;
    assign o_sts.clr_last = (32'(r_clr_idx) == 32'(CLR_N - 1));
    assign o_sts.act      = r_item.action;
    assign o_sts.way_ok   = way_ok;
    assign o_sts.train    = train;
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> (!r_out_valid || !i_out_stall))
        else $error("result overwrites a stalled beat");

    a_push_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |=> r_out_valid)
        else $error("pushed result not presented");

    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clr |-> !(i_cmd.load || i_cmd.eval || i_cmd.count))
        else $error("item work during clearing pass");

endmodule

// File: rtl/ship_rrip_replacement.sv
// Top level of the signature-based RRIP replacement engine.
`timescale 1ns / 1ps
//
//  channel   direction  handshake                  payload
//  in        input      i_in_valid / o_in_stall    i_in_beat  (action, set, way, signature)
//  out       output     o_out_valid / i_out_stall  o_out_beat (victim way, invalid flag)
//  cfg       input      i_cfg_wr_en                i_cfg_wr_data (hit priority)
//
//  A fill or a dropped beat passes through the idle, reduce and evaluate
//  states; a hit to a way in range adds a counter update, and a victim
//  request adds a counter update when it trains, then a push plus any wait
//  on a stalled output register; line-state rows and counters are read
//  and written in turn. After reset a clearing pass over every entry of
//  max(NUM_SETS, TABLE_ENTRIES) zeroes the valid bits and counters;
//  o_in_stall stays high through it. Reset is synchronous, active low. A
//  finished result waits in the output register while the next beat is already taken.

module ship_rrip_replacement #(
    parameter int RRPV_BITS     = 2,
    parameter int COUNTER_BITS  = 3,
    parameter int TABLE_ENTRIES = 16384,
    parameter int NUM_WAYS      = 16,
    parameter int NUM_SETS      = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  ship_pkg::t_in_beat  i_in_beat,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ship_pkg::t_out_beat o_out_beat,
    input  logic                i_cfg_wr_en,
    input  logic                i_cfg_wr_data
);
    import ship_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    // Sequence each beat: load, reduce set and signature, evaluate, train, push.
    ship_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Hold line state, counters, the hit-priority register and the result.
    ship_dp #(
        .RRPV_BITS     (RRPV_BITS),
        .COUNTER_BITS  (COUNTER_BITS),
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .NUM_WAYS      (NUM_WAYS),
        .NUM_SETS      (NUM_SETS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_beat     (i_in_beat),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_out_beat    (o_out_beat),
        .i_cmd         (cmd),
        .o_sts         (sts)
    );

endmodule

// File: sim/tb.sv
// Testbench for the signature-based RRIP replacement engine: directed table plus random traffic.
`timescale 1ns / 1ps

module tb;
    import ship_pkg::*;

    localparam int WAYS      = 16;
    localparam int LINES     = 1024 * WAYS;
    localparam int TBL       = 16384;
    localparam int IDLE_MAX  = 60000;   // covers the clearing pass after reset
    localparam logic [1:0] ACT_NONE = 2'd3;
    localparam logic [1:0] RRPV_TOP = 2'd3;
    localparam logic [2:0] CTR_TOP  = 3'd7;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in_beat    i_in_beat;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out_beat   o_out_beat;
    logic        i_cfg_wr_en;
    logic        i_cfg_wr_data;

    ship_rrip_replacement dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_beat    (i_in_beat),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_beat   (o_out_beat),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data)
    );

    // Shadow copy of line state and the reuse counter table.
    logic [1:0]  shadow_rrpv   [LINES];
    logic        shadow_valid  [LINES];
    logic        shadow_reused [LINES];
    logic [13:0] shadow_sig    [LINES];
    logic [2:0]  shadow_ctr    [TBL];
    logic        shadow_hit_zero;

    t_out_beat   victim_q[$];
    int          errors;
    int          idle_cycles;
    bit          long_hold;
    bit          hold_go;

    typedef struct {
        t_in_beat  beat;
        bit        typed;
        t_out_beat want;
    } t_row;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Advance the shadow state by one accepted beat; return 1 with the victim if any.
    function automatic bit predict_victim(t_in_beat b, output t_out_beat res);
        int base;
        int line;
        int best;
        logic [1:0] top;
        logic [2:0] diff;
        logic [2:0] sum;
        base = int'(b.set_index) * WAYS;
        line = base + int'(b.way);
        res = '0;
        case (b.action)
            ACT_HIT: begin
                if (shadow_ctr[shadow_sig[line]] < CTR_TOP)
                    shadow_ctr[shadow_sig[line]]++;
                shadow_reused[line] = 1'b1;
                if (shadow_hit_zero)
                    shadow_rrpv[line] = 2'd0;
                else if (shadow_rrpv[line] > 0)
                    shadow_rrpv[line]--;
                return 1'b0;
            end
            ACT_FILL: begin
                shadow_rrpv[line]   = (shadow_ctr[b.signature] != 0) ? RRPV_TOP - 2'd1
                                                                     : RRPV_TOP;
                shadow_sig[line]    = b.signature;
                shadow_valid[line]  = 1'b1;
                shadow_reused[line] = 1'b0;
                return 1'b0;
            end
            ACT_VICTIM: begin
                for (int w = 0; w < WAYS; w++) begin
                    if (!shadow_valid[base + w]) begin
                        res.victim_way = w[3:0];
                        res.victim_invalid = 1'b1;
                        return 1'b1;
                    end
                end
                best = 0;
                top = shadow_rrpv[base];
                for (int w = 1; w < WAYS; w++) begin
                    if (shadow_rrpv[base + w] > top) begin
                        best = w;
                        top = shadow_rrpv[base + w];
                    end
                end
                // Age the whole set until the victim sits at the top value.
                diff = {1'b0, RRPV_TOP - top};
                for (int w = 0; w < WAYS; w++) begin
                    sum = {1'b0, shadow_rrpv[base + w]} + diff;
                    shadow_rrpv[base + w] = (sum > RRPV_TOP) ? RRPV_TOP : sum[1:0];
                end
                if (!shadow_reused[base + best] && shadow_ctr[shadow_sig[base + best]] > 0)
                    shadow_ctr[shadow_sig[base + best]]--;
                res.victim_way = best[3:0];
                res.victim_invalid = 1'b0;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    // Offer one beat, hold it until taken, then log the expectation.
    task automatic send_beat(t_in_beat b, bit typed, t_out_beat want);
        t_out_beat res;
        i_in_valid <= 1'b1;
        i_in_beat  <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (predict_victim(b, res))
            victim_q.push_back(typed ? want : res);
    endtask

    task automatic sender_gap();
        int gap;
        gap = 0;
        if ($urandom_range(0, 7) == 0)
            gap = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 3);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drain, let trailing hits and fills retire, then write the register.
    task automatic write_hit_mode(bit mode);
        i_in_valid <= 1'b0;
        wait (victim_q.size() == 0);
        repeat (12) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= mode;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        shadow_hit_zero = mode;
    endtask

    function automatic logic [9:0] pick_set();
        logic [9:0] pool[8] = '{10'd0, 10'd1023, 10'd1, 10'd512, 10'd341, 10'd682,
                                10'd100, 10'd900};
        if ($urandom_range(0, 9) == 0)
            return 10'($urandom);
        return pool[$urandom_range(0, 7)];
    endfunction

    function automatic logic [13:0] pick_sig();
        if ($urandom_range(0, 9) < 3)
            return 14'($urandom);
        case ($urandom_range(0, 5))
            0: return 14'h0000;
            1: return 14'h3FFF;
            default: return 14'($urandom_range(1, 12));
        endcase
    endfunction

    // Mostly well-formed traffic on a few hot sets, a little noise.
    task automatic random_beats(int count);
        t_in_beat b;
        int sel;
        int base;
        bit found;
        for (int n = 0; n < count; n++) begin
            if (n == count / 2 && !hold_go)
                hold_go = 1'b1;
            b.set_index = pick_set();
            b.way       = 4'($urandom);
            b.signature = pick_sig();
            sel = $urandom_range(0, 99);
            if (sel < 38)
                b.action = ACT_FILL;
            else if (sel < 70)
                b.action = ACT_HIT;
            else if (sel < 95)
                b.action = ACT_VICTIM;
            else
                b.action = ACT_NONE;
            if (b.action == ACT_HIT) begin
                // Hit only lines that were filled; never read an unwritten line.
                base = int'(b.set_index) * WAYS;
                found = shadow_valid[base + int'(b.way)];
                for (int w = 0; w < WAYS && !found; w++) begin
                    if (shadow_valid[base + w]) begin
                        b.way = w[3:0];
                        found = 1'b1;
                    end
                end
                if (!found)
                    b.action = ACT_FILL;
            end
            send_beat(b, 1'b0, '0);
            sender_gap();
        end
    endtask

    // Receiver: random stall bursts, plus one long hold-off on request.
    initial begin
        int left;
        left = 0;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall) begin
                if (victim_q.size() == 0) begin
                    report("unexpected victim beat", o_out_beat.victim_way, -1);
                end else begin
                    if (o_out_beat.victim_way != victim_q[0].victim_way)
                        report("victim_way", o_out_beat.victim_way, victim_q[0].victim_way);
                    if (o_out_beat.victim_invalid != victim_q[0].victim_invalid)
                        report("victim_invalid", o_out_beat.victim_invalid,
                               victim_q[0].victim_invalid);
                    void'(victim_q.pop_front());
                end
            end
            if (left > 0) begin
                left--;
            end else if ($urandom_range(0, 5) == 0) begin
                left = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(1, 3);
            end
            i_out_stall <= long_hold || (left > 0);
        end
    end

    initial begin
        wait (hold_go);
        @(posedge i_clk);
        long_hold = 1'b1;
        repeat (400) @(posedge i_clk);
        long_hold = 1'b0;
    end

    // Watchdog: end the run when nothing moves for too long.
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_MAX) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin
        t_row rows[$];
        errors = 0;
        long_hold = 1'b0;
        hold_go = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_beat = '0;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = 1'b0;
        shadow_hit_zero = 1'b1;
        for (int i = 0; i < LINES; i++) begin
            shadow_rrpv[i] = '0;
            shadow_valid[i] = 1'b0;
            shadow_reused[i] = 1'b0;
            shadow_sig[i] = '0;
        end
        for (int i = 0; i < TBL; i++)
            shadow_ctr[i] = '0;

        // action, set, way, signature | typed | victim_way, invalid
        rows.push_back('{'{ACT_VICTIM, 10'd0,    4'd0,  14'h0000}, 1, '{4'd0, 1'b1}});
        rows.push_back('{'{ACT_VICTIM, 10'd1023, 4'd15, 14'h3FFF}, 1, '{4'd0, 1'b1}});
        rows.push_back('{'{ACT_NONE,   10'd1023, 4'd15, 14'h3FFF}, 0, '0});
        rows.push_back('{'{ACT_FILL,   10'd1023, 4'd0,  14'h3FFF}, 0, '0});
        rows.push_back('{'{ACT_VICTIM, 10'd1023, 4'd0,  14'h0000}, 1, '{4'd1, 1'b1}});
        rows.push_back('{'{ACT_HIT,    10'd1023, 4'd0,  14'h0000}, 0, '0});
        rows.push_back('{'{ACT_FILL,   10'd0,    4'd15, 14'h0000}, 0, '0});
        rows.push_back('{'{ACT_VICTIM, 10'd0,    4'd15, 14'h0000}, 1, '{4'd0, 1'b1}});
        for (int w = 0; w < WAYS; w++)
            rows.push_back('{'{ACT_FILL, 10'd7, w[3:0], 14'(w % 3)}, 0, '0});
        rows.push_back('{'{ACT_VICTIM, 10'd7, 4'd0, 14'h0000}, 0, '0});
        rows.push_back('{'{ACT_HIT,    10'd7, 4'd3, 14'h0000}, 0, '0});
        rows.push_back('{'{ACT_VICTIM, 10'd7, 4'd9, 14'h0000}, 0, '0});

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[k]) begin
            send_beat(rows[k].beat, rows[k].typed, rows[k].want);
            sender_gap();
        end

        write_hit_mode(1'b0);
        random_beats(600);
        write_hit_mode(1'b1);
        random_beats(600);
        write_hit_mode(1'b0);
        random_beats(600);

        i_in_valid <= 1'b0;
        wait (victim_q.size() == 0);
        repeat (20) @(posedge i_clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
